// ===== design/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants for the run-length tape machine.
// ----------------------------------------------------------------------------
package tle_pkg;

  // Default sizes
  localparam int unsigned ProgDepthDef = 1024;
  localparam int unsigned TapeDepthDef = 4096;
  localparam int unsigned CellBitsDef  = 8;
  localparam int unsigned CountBitsDef = 16;

  // Fixed port widths
  localparam int unsigned RepeatW = 16;
  localparam int unsigned PcOutW  = 11;
  localparam int unsigned PosOutW = 12;
  localparam int unsigned OpW     = 8;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_EXECUTE = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_ERASE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_OVERRUN = 2'd1,
    FAULT_BRACKET = 2'd2,
    FAULT_FULL    = 2'd3
  } fault_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MATCH_RD,
    ST_MATCH_CHK
  } state_e;

  // Opcode characters
  localparam logic [OpW-1:0] OP_CLEAR = 8'h2A;  // '*'
  localparam logic [OpW-1:0] OP_ADD   = 8'h2B;  // '+'
  localparam logic [OpW-1:0] OP_SUB   = 8'h2D;  // '-'
  localparam logic [OpW-1:0] OP_HOME  = 8'h5E;  // '^'
  localparam logic [OpW-1:0] OP_LEFT  = 8'h3C;  // '<'
  localparam logic [OpW-1:0] OP_RIGHT = 8'h3E;  // '>'
  localparam logic [OpW-1:0] OP_LB    = 8'h5B;  // '['
  localparam logic [OpW-1:0] OP_RB    = 8'h5D;  // ']'
  localparam logic [OpW-1:0] OP_IN    = 8'h2C;  // ','
  localparam logic [OpW-1:0] OP_OUT   = 8'h2E;  // '.'
  localparam logic [OpW-1:0] OP_ERR   = 8'h26;  // '&'
  localparam logic [OpW-1:0] OP_SCANL = 8'h7B;  // '{'
  localparam logic [OpW-1:0] OP_SCANR = 8'h7D;  // '}'
  localparam logic [OpW-1:0] OP_HALT  = 8'h40;  // '@'

  localparam logic [7:0] CellMod = 8'd255;

endpackage

// ===== design/tle_ram.sv =====
// ----------------------------------------------------------------------------
// tle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/tape_language_executor.sv =====
// ----------------------------------------------------------------------------
// tape_language_executor
// Run-length tape machine: program store and cell tape in synchronous RAMs.
// ----------------------------------------------------------------------------
// Steps: append, erase, restart and stopped steps register their result as
//   they are taken; a plain execute reads program and tape, then writes the
//   tape back in ST_EXEC. Zero scans pass ST_SCAN_RD and ST_SCAN_CHK per cell,
//   bracket jumps ST_MATCH_RD and ST_MATCH_CHK per instruction walked, both
//   bound by the single RAM read port. One request in flight; the next is
//   taken once the result has been taken. Reset and restart run a tape clearing pass.
module tape_language_executor #(
  parameter int unsigned PROG_DEPTH = tle_pkg::ProgDepthDef,
  parameter int unsigned TAPE_DEPTH = tle_pkg::TapeDepthDef,
  parameter int unsigned CELL_BITS  = tle_pkg::CellBitsDef,
  parameter int unsigned COUNT_BITS = tle_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [tle_pkg::OpW-1:0]       op_char_i,
  input  logic [tle_pkg::RepeatW-1:0]   repeat_req_i,
  input  logic [CELL_BITS-1:0]          in_byte_i,
  input  logic                          in_eof_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic                          out_valid_o,
  output logic [CELL_BITS-1:0]          out_byte_o,
  output logic                          out_error_channel_o,
  output logic                          used_input_o,
  output logic                          halted_o,
  output logic [1:0]                    fault_o,
  output logic [tle_pkg::PcOutW-1:0]    prog_counter_o,
  output logic [tle_pkg::PosOutW-1:0]   tape_position_o
);

  import tle_pkg::*;

  localparam int unsigned PcW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned PaW = $clog2(PROG_DEPTH);
  localparam int unsigned TpW = $clog2(TAPE_DEPTH);
  localparam int unsigned PwW = OpW + COUNT_BITS;
  localparam int unsigned SumW = ((COUNT_BITS > TpW) ? COUNT_BITS : TpW) + 1;
  localparam logic [TpW-1:0] TapeLast = TpW'(TAPE_DEPTH - 1);

  state_e                state_q, state_d;
  logic [PcW-1:0]        len_q, len_d;
  logic [PcW-1:0]        pc_q, pc_d;
  logic [TpW-1:0]        head_q, head_d;
  logic                  stop_q, stop_d;
  logic [1:0]            fault_q, fault_d;
  logic [PcW-1:0]        k_q, k_d;
  logic [PcW:0]          depth_q, depth_d;
  logic [TpW-1:0]        scan_q, scan_d;
  logic                  fwd_q, fwd_d;
  logic [TpW-1:0]        clr_q, clr_d;
  logic [CELL_BITS-1:0]  inb_q, inb_d;
  logic                  ineof_q, ineof_d;
  logic                  rv_q, rv_d;

  logic                  ov_q, ov_d, oe_q, oe_d, ui_q, ui_d, hl_q, hl_d;
  logic [CELL_BITS-1:0]  ob_q, ob_d;
  logic [1:0]            of_q, of_d;
  logic [PcOutW-1:0]     opc_q, opc_d;
  logic [PosOutW-1:0]    opos_q, opos_d;

  logic                  prog_we;
  logic [PaW-1:0]        prog_raddr;
  logic [PwW-1:0]        prog_rd;
  logic                  tape_we;
  logic [TpW-1:0]        tape_waddr, tape_raddr;
  logic [CELL_BITS-1:0]  tape_wdata, tape_rd;

  logic                  in_acc, fin;
  logic                  f_ov, f_oe, f_ui;
  logic [CELL_BITS-1:0]  f_ob;
  logic [OpW-1:0]        op;
  logic [COUNT_BITS-1:0] cnt;
  logic [SumW-1:0]       rsum;
  logic [PcW-1:0]        kn;
  logic [PcW:0]          dn;

  assign in_stall_o = (state_q != ST_IDLE) || rv_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign op         = prog_rd[OpW-1:0];
  assign cnt        = prog_rd[PwW-1:OpW];
  assign rsum       = SumW'(head_q) + SumW'(cnt);

  tle_ram #(.WIDTH(PwW), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (len_q[PaW-1:0]),
    .wdata_i ({COUNT_BITS'(repeat_req_i), op_char_i}),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rd)
  );

  tle_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_DEPTH)) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (tape_raddr),
    .rdata_o (tape_rd)
  );

  // Next state, memory accesses and result capture
  always_comb begin
    state_d = state_q;
    len_d = len_q;
    pc_d = pc_q;
    head_d = head_q;
    stop_d = stop_q;
    fault_d = fault_q;
    k_d = k_q;
    depth_d = depth_q;
    scan_d = scan_q;
    fwd_d = fwd_q;
    clr_d = clr_q;
    inb_d = inb_q;
    ineof_d = ineof_q;
    prog_we = 1'b0;
    prog_raddr = pc_q[PaW-1:0];
    tape_we = 1'b0;
    tape_waddr = head_q;
    tape_wdata = '0;
    tape_raddr = head_q;
    fin = 1'b0;
    f_ov = 1'b0;
    f_oe = 1'b0;
    f_ui = 1'b0;
    f_ob = '0;
    kn = k_q;
    dn = depth_q;

    case (state_q)
      ST_CLEAR: begin
        tape_we = 1'b1;
        tape_waddr = clr_q;
        if (clr_q == TapeLast) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(cmd_i))
            CMD_APPEND: begin
              fin = 1'b1;
              if (len_q == PcW'(PROG_DEPTH)) begin
                stop_d = 1'b1;
                fault_d = FAULT_FULL;
              end else begin
                prog_we = 1'b1;
                len_d = len_q + 1'b1;
              end
            end
            CMD_EXECUTE: begin
              if (stop_q) begin
                fin = 1'b1;
              end else if (pc_q >= len_q) begin
                stop_d = 1'b1;
                fin = 1'b1;
              end else begin
                inb_d = in_byte_i;
                ineof_d = in_eof_i;
                state_d = ST_EXEC;
              end
            end
            CMD_RESTART: begin
              head_d = '0;
              pc_d = '0;
              stop_d = 1'b0;
              fault_d = FAULT_NONE;
              clr_d = '0;
              state_d = ST_CLEAR;
              fin = 1'b1;
            end
            CMD_ERASE: begin
              len_d = '0;
              pc_d = '0;
              stop_d = 1'b0;
              fault_d = FAULT_NONE;
              fin = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        fin = 1'b1;
        pc_d = pc_q + 1'b1;
        case (op)
          OP_CLEAR: begin
            tape_we = 1'b1;
          end
          OP_ADD: begin
            tape_we = 1'b1;
            tape_wdata = tape_rd + CELL_BITS'(cnt);
          end
          OP_SUB: begin
            tape_we = 1'b1;
            tape_wdata = tape_rd - CELL_BITS'(cnt);
          end
          OP_HOME: head_d = '0;
          OP_LEFT: begin
            if (SumW'(cnt) <= SumW'(head_q)) begin
              head_d = head_q - TpW'(cnt);
            end
          end
          OP_RIGHT: begin
            if (rsum >= SumW'(TAPE_DEPTH)) begin
              stop_d = 1'b1;
              fault_d = FAULT_OVERRUN;
              pc_d = pc_q;
            end else begin
              head_d = rsum[TpW-1:0];
            end
          end
          OP_LB: begin
            if (tape_rd == '0) begin
              fin = 1'b0;
              pc_d = pc_q;
              k_d = pc_q;
              depth_d = (PcW+1)'(1);
              fwd_d = 1'b1;
              state_d = ST_MATCH_RD;
            end
          end
          OP_RB: begin
            if (tape_rd != '0) begin
              fin = 1'b0;
              pc_d = pc_q;
              k_d = pc_q;
              depth_d = (PcW+1)'(1);
              fwd_d = 1'b0;
              state_d = ST_MATCH_RD;
            end
          end
          OP_IN: begin
            tape_we = 1'b1;
            tape_wdata = ineof_q ? '0 : inb_q;
            f_ui = 1'b1;
          end
          OP_OUT: begin
            f_ov = 1'b1;
            f_ob = (tape_rd == CellMod) ? '0 : tape_rd;
          end
          OP_ERR: begin
            f_ov = 1'b1;
            f_oe = 1'b1;
            f_ob = tape_rd;
          end
          OP_SCANL, OP_SCANR: begin
            fin = 1'b0;
            pc_d = pc_q;
            scan_d = head_q;
            fwd_d = (op == OP_SCANR);
            state_d = ST_SCAN_RD;
          end
          OP_HALT: begin
            stop_d = 1'b1;
            pc_d = pc_q;
          end
          default: ;
        endcase
      end
      ST_SCAN_RD: begin
        tape_raddr = scan_q;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (tape_rd == '0) begin
          head_d = scan_q;
          pc_d = pc_q + 1'b1;
          fin = 1'b1;
          state_d = ST_IDLE;
        end else if (fwd_q ? (scan_q == TapeLast) : (scan_q == '0)) begin
          pc_d = pc_q + 1'b1;
          fin = 1'b1;
          state_d = ST_IDLE;
        end else begin
          scan_d = fwd_q ? scan_q + 1'b1 : scan_q - 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_MATCH_RD: begin
        // Step to the neighbour instruction or give up at either end
        if (fwd_q ? (k_q + 1'b1 >= len_q) : (k_q == '0)) begin
          stop_d = 1'b1;
          fault_d = FAULT_BRACKET;
          fin = 1'b1;
          state_d = ST_IDLE;
        end else begin
          kn = fwd_q ? k_q + 1'b1 : k_q - 1'b1;
          k_d = kn;
          prog_raddr = kn[PaW-1:0];
          state_d = ST_MATCH_CHK;
        end
      end
      ST_MATCH_CHK: begin
        if (op == OP_LB) begin
          dn = fwd_q ? depth_q + 1'b1 : depth_q - 1'b1;
        end else if (op == OP_RB) begin
          dn = fwd_q ? depth_q - 1'b1 : depth_q + 1'b1;
        end
        if (dn == '0) begin
          pc_d = k_q + 1'b1;
          fin = 1'b1;
          state_d = ST_IDLE;
        end else begin
          depth_d = dn;
          state_d = ST_MATCH_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Result register: drop once taken, load on completion
    rv_d = rv_q && res_stall_i;
    ov_d = ov_q;
    ob_d = ob_q;
    oe_d = oe_q;
    ui_d = ui_q;
    hl_d = hl_q;
    of_d = of_q;
    opc_d = opc_q;
    opos_d = opos_q;
    if (fin) begin
      rv_d = 1'b1;
      ov_d = f_ov;
      ob_d = f_ob;
      oe_d = f_oe;
      ui_d = f_ui;
      hl_d = stop_d;
      of_d = fault_d;
      opc_d = PcOutW'(pc_d);
      opos_d = PosOutW'(head_d);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      len_q <= '0;
      pc_q <= '0;
      head_q <= '0;
      stop_q <= 1'b0;
      fault_q <= FAULT_NONE;
      clr_q <= '0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      pc_q <= pc_d;
      head_q <= head_d;
      stop_q <= stop_d;
      fault_q <= fault_d;
      clr_q <= clr_d;
      rv_q <= rv_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    depth_q <= depth_d;
    scan_q <= scan_d;
    fwd_q <= fwd_d;
    inb_q <= inb_d;
    ineof_q <= ineof_d;
    ov_q <= ov_d;
    ob_q <= ob_d;
    oe_q <= oe_d;
    ui_q <= ui_d;
    hl_q <= hl_d;
    of_q <= of_d;
    opc_q <= opc_d;
    opos_q <= opos_d;
  end

  assign res_valid_o = rv_q;
  assign out_valid_o = ov_q;
  assign out_byte_o = ob_q;
  assign out_error_channel_o = oe_q;
  assign used_input_o = ui_q;
  assign halted_o = hl_q;
  assign fault_o = of_q;
  assign prog_counter_o = opc_q;
  assign tape_position_o = opos_q;

  // Checks
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= TapeLast) else $error("head beyond tape");
  a_pc_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= len_q) else $error("counter beyond program");
  a_fault_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q != FAULT_NONE |-> stop_q) else $error("fault without stop");
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !tape_we) else $error("tape write while idle");
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !rv_q) else $error("result overwritten");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length tape machine: requests are queued by
// a stimulus process, driven at the falling edge under random idling, and
// every result is compared with the step predicted by a behavioural copy of
// the machine kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import tle_pkg::*;

  localparam int unsigned ProgDepth = 1024;
  localparam int unsigned TapeDepth = 4096;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  op_char;
    logic [15:0] repeat_req;
    logic [7:0]  in_byte;
    logic        in_eof;
  } request_t;

  typedef struct {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_err;
    logic        used_input;
    logic        halted;
    logic [1:0]  fault;
    logic [10:0] prog_counter;
    logic [11:0] tape_position;
  } step_res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] cmd_i;
  logic [7:0] op_char_i;
  logic [15:0] repeat_req_i;
  logic [7:0] in_byte_i;
  logic in_eof_i;
  logic res_valid_o;
  logic res_stall_i;
  logic out_valid_o;
  logic [7:0] out_byte_o;
  logic out_error_channel_o;
  logic used_input_o;
  logic halted_o;
  logic [1:0] fault_o;
  logic [10:0] prog_counter_o;
  logic [11:0] tape_position_o;

  tape_language_executor u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .op_char_i,
    .repeat_req_i, .in_byte_i, .in_eof_i, .res_valid_o, .res_stall_i,
    .out_valid_o, .out_byte_o, .out_error_channel_o, .used_input_o,
    .halted_o, .fault_o, .prog_counter_o, .tape_position_o
  );

  // Predictor state
  logic [7:0]  m_ops [ProgDepth];
  logic [15:0] m_cnts [ProgDepth];
  int unsigned m_len;
  int unsigned m_pc;
  logic [7:0]  m_tape [TapeDepth];
  int unsigned m_head;
  logic        m_stopped;
  logic [1:0]  m_fault;

  request_t  pending_reqs[$];
  step_res_t expected_steps[$];
  int unsigned errors = 0;
  int unsigned send_idle = 6;
  int unsigned recv_idle = 75;
  bit          stim_done = 0;
  bit          in_taken = 0;

  // Clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic void clear_tape();
    for (int i = 0; i < TapeDepth; i++) m_tape[i] = 8'd0;
    m_head = 0;
    m_pc = 0;
    m_stopped = 1'b0;
    m_fault = FAULT_NONE;
  endfunction

  // Walk the program for the partner bracket; -1 when there is none
  function automatic int find_partner(int unsigned at, bit fwd);
    int unsigned depth;
    int unsigned k;
    depth = 1;
    k = at;
    forever begin
      if (fwd) begin
        if (k + 1 >= m_len) return -1;
        k++;
      end else begin
        if (k == 0) return -1;
        k--;
      end
      if (m_ops[k] == OP_LB) depth = fwd ? depth + 1 : depth - 1;
      else if (m_ops[k] == OP_RB) depth = fwd ? depth - 1 : depth + 1;
      if (depth == 0) return k;
    end
  endfunction

  // Advance the machine by one request and return its step status
  function automatic step_res_t machine_step(request_t rq);
    step_res_t r;
    logic [7:0] op;
    int unsigned cnt;
    int unsigned nxt;
    int m;
    bit done;
    r = '{default: '0};
    case (cmd_e'(rq.cmd))
      CMD_APPEND: begin
        if (m_len >= ProgDepth) begin
          m_stopped = 1'b1;
          m_fault = FAULT_FULL;
        end else begin
          m_ops[m_len] = rq.op_char;
          m_cnts[m_len] = rq.repeat_req;
          m_len++;
        end
      end
      CMD_EXECUTE: begin
        if (!m_stopped) begin
          if (m_pc >= m_len) m_stopped = 1'b1;
          else begin
            op = m_ops[m_pc];
            cnt = m_cnts[m_pc];
            nxt = m_pc + 1;
            done = 1'b0;
            case (op)
              OP_CLEAR: m_tape[m_head] = 8'd0;
              OP_ADD:   m_tape[m_head] = m_tape[m_head] + cnt[7:0];
              OP_SUB:   m_tape[m_head] = m_tape[m_head] - cnt[7:0];
              OP_HOME:  m_head = 0;
              OP_LEFT:  if (cnt <= m_head) m_head -= cnt;
              OP_RIGHT: begin
                if (m_head + cnt >= TapeDepth) begin
                  m_stopped = 1'b1;
                  m_fault = FAULT_OVERRUN;
                  done = 1'b1;
                end else m_head += cnt;
              end
              OP_LB, OP_RB: begin
                if ((op == OP_LB) == (m_tape[m_head] == 8'd0)) begin
                  m = find_partner(m_pc, op == OP_LB);
                  if (m < 0) begin
                    m_stopped = 1'b1;
                    m_fault = FAULT_BRACKET;
                    done = 1'b1;
                  end else nxt = m + 1;
                end
              end
              OP_IN: begin
                m_tape[m_head] = rq.in_eof ? 8'd0 : rq.in_byte;
                r.used_input = 1'b1;
              end
              OP_OUT: begin
                r.out_valid = 1'b1;
                r.out_byte = m_tape[m_head] % CellMod;
              end
              OP_ERR: begin
                r.out_valid = 1'b1;
                r.out_byte = m_tape[m_head];
                r.out_err = 1'b1;
              end
              OP_SCANL: begin
                for (int k = m_head; k >= 0; k--)
                  if (m_tape[k] == 8'd0) begin
                    m_head = k;
                    break;
                  end
              end
              OP_SCANR: begin
                for (int k = m_head; k < TapeDepth; k++)
                  if (m_tape[k] == 8'd0) begin
                    m_head = k;
                    break;
                  end
              end
              OP_HALT: begin
                m_stopped = 1'b1;
                done = 1'b1;
              end
              default: ;
            endcase
            if (!done) m_pc = nxt;
          end
        end
      end
      CMD_RESTART: clear_tape();
      default: begin
        m_len = 0;
        m_pc = 0;
        m_stopped = 1'b0;
        m_fault = FAULT_NONE;
      end
    endcase
    r.halted = m_stopped;
    r.fault = m_fault;
    r.prog_counter = m_pc[10:0];
    r.tape_position = m_head[11:0];
    return r;
  endfunction

  function automatic request_t mk(logic [1:0] c, logic [7:0] o, logic [15:0] n);
    request_t q;
    q.cmd = c;
    q.op_char = o;
    q.repeat_req = n;
    q.in_byte = 8'($urandom);
    q.in_eof = ($urandom_range(0, 7) == 0);
    return q;
  endfunction

  function automatic logic [7:0] pick_op();
    logic [7:0] ops [14] = '{OP_CLEAR, OP_ADD, OP_SUB, OP_HOME, OP_LEFT, OP_RIGHT,
      OP_LB, OP_RB, OP_IN, OP_OUT, OP_ERR, OP_SCANL, OP_SCANR, OP_HALT};
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return ops[$urandom_range(0, 13)];
  endfunction

  function automatic logic [15:0] pick_count(logic [7:0] op);
    if ($urandom_range(0, 15) == 0) return 16'($urandom);
    if (op == OP_RIGHT || op == OP_LEFT) return 16'($urandom_range(0, 6));
    return 16'($urandom_range(0, 300));
  endfunction

  // Driver: present the next request at the falling edge once the last one is taken
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_valid_i <= 1'b1;
        cmd_i <= pending_reqs[0].cmd;
        op_char_i <= pending_reqs[0].op_char;
        repeat_req_i <= pending_reqs[0].repeat_req;
        in_byte_i <= pending_reqs[0].in_byte;
        in_eof_i <= pending_reqs[0].in_eof;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver idling
  always @(negedge clk_i) res_stall_i <= ($urandom_range(0, 99) < recv_idle);

  // Predict each accepted request
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_steps.push_back(machine_step('{cmd_i, op_char_i, repeat_req_i,
                                              in_byte_i, in_eof_i}));
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    step_res_t e;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (expected_steps.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_steps.pop_front();
        if (out_valid_o !== e.out_valid) begin
          $error("out_valid exp %0h got %0h", e.out_valid, out_valid_o); errors++;
        end
        if (out_byte_o !== e.out_byte) begin
          $error("out_byte exp %0h got %0h", e.out_byte, out_byte_o); errors++;
        end
        if (out_error_channel_o !== e.out_err) begin
          $error("out_error_channel exp %0h got %0h", e.out_err, out_error_channel_o);
          errors++;
        end
        if (used_input_o !== e.used_input) begin
          $error("used_input exp %0h got %0h", e.used_input, used_input_o); errors++;
        end
        if (halted_o !== e.halted) begin
          $error("halted exp %0h got %0h", e.halted, halted_o); errors++;
        end
        if (fault_o !== e.fault) begin
          $error("fault exp %0h got %0h", e.fault, fault_o); errors++;
        end
        if (prog_counter_o !== e.prog_counter) begin
          $error("prog_counter exp %0h got %0h", e.prog_counter, prog_counter_o);
          errors++;
        end
        if (tape_position_o !== e.tape_position) begin
          $error("tape_position exp %0h got %0h", e.tape_position, tape_position_o);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned plen;
    int unsigned nexec;
    logic [7:0] op;
    m_len = 0;
    clear_tape();
    in_valid_i = 1'b0;
    res_stall_i = 1'b0;
    cmd_i = CMD_APPEND;
    op_char_i = '0;
    repeat_req_i = '0;
    in_byte_i = '0;
    in_eof_i = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: eight ops (one unknown) with edge counts, end of program, stopped execute
    pending_reqs.push_back(mk(CMD_EXECUTE, 8'd0, 16'd0));
    pending_reqs.push_back(mk(CMD_ERASE, 8'd0, 16'd0));
    pending_reqs.push_back(mk(CMD_APPEND, OP_SUB, 16'hFFFF));
    pending_reqs.push_back(mk(CMD_APPEND, OP_OUT, 16'd0));
    pending_reqs.push_back(mk(CMD_APPEND, OP_ERR, 16'd0));
    pending_reqs.push_back(mk(CMD_APPEND, OP_LEFT, 16'd1));
    pending_reqs.push_back(mk(CMD_APPEND, OP_SCANR, 16'd0));
    pending_reqs.push_back(mk(CMD_APPEND, OP_RB, 16'd0));
    pending_reqs.push_back(mk(CMD_APPEND, 8'hFF, 16'd0));
    pending_reqs.push_back(mk(CMD_APPEND, OP_RIGHT, 16'hFFFF));
    for (int i = 0; i < 9; i++) pending_reqs.push_back(mk(CMD_EXECUTE, 8'd0, 16'd0));
    pending_reqs.push_back(mk(CMD_RESTART, 8'd0, 16'd0));
    pending_reqs.push_back(mk(CMD_ERASE, 8'd0, 16'd0));

    // Random programs: mostly short loops; one fills the store to overflow
    while (pending_reqs.size() + expected_steps.size() < 2000 && !stim_done) begin
      for (int ph = 0; ph < 3; ph++) begin
        if (ph == 1) begin
          send_idle = 75;
          recv_idle = 6;
        end else if (ph == 2) begin
          send_idle = 0;
          recv_idle = 0;
        end
        for (int p = 0; p < 5; p++) begin
          if (p == 2 && ph == 0) plen = ProgDepth + 1;
          else plen = $urandom_range(3, 24);
          if ($urandom_range(0, 2) == 0)
            pending_reqs.push_back(mk(CMD_RESTART, 8'd0, 16'd0));
          for (int i = 0; i < plen; i++) begin
            op = pick_op();
            pending_reqs.push_back(mk(CMD_APPEND, op, pick_count(op)));
          end
          nexec = $urandom_range(10, 40);
          for (int i = 0; i < nexec; i++) begin
            if ($urandom_range(0, 19) == 0)
              pending_reqs.push_back(mk(2'($urandom), 8'($urandom), 16'($urandom)));
            else pending_reqs.push_back(mk(CMD_EXECUTE, 8'($urandom), 16'($urandom)));
          end
          pending_reqs.push_back(mk(CMD_ERASE, 8'd0, 16'd0));
        end
        // Let this phase drain before switching idling
        wait (pending_reqs.size() == 0 && expected_steps.size() == 0);
      end
      stim_done = 1;
    end

    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_steps.size() == 0);
    repeat (TapeDepth * 3) @(posedge clk_i);
    if (errors == 0 && expected_steps.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/tle_pkg.sv
design/tle_ram.sv
design/tape_language_executor.sv
tb/tb_top.sv
